/* sv/bpsg_pkg.sv */
// Shared types and constants for the block power squelch gate.
// No dependencies; the other files that use it refer to this package by scoped names.
package bpsg_pkg;

    // register map and register widths
    localparam int LEN_W     = 6;
    localparam int LEVEL_W   = 16;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_LEN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SQUELCH   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCKING  = 2'd2;

    localparam logic [LEN_W-1:0]   RST_BLOCK_LEN = 6'd32;
    localparam logic [LEVEL_W-1:0] RST_SQUELCH   = 16'd328;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SQUARE,
        S_ADD,
        S_ROOT,
        S_ACCUM,
        S_THRESH,
        S_DECIDE,
        S_PLAN,
        S_READ,
        S_LOAD,
        S_ZERO
    } t_state;

    typedef struct packed {
        logic take;
        logic square;
        logic add;
        logic root;
        logic accum;
        logic thresh;
        logic decide;
        logic rd;
        logic load_data;
        logic load_zero;
        logic burst_end;
        logic emit_next;
        logic emit_clr;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic root_done;
        logic block_full;
        logic decide;
        logic was_open;
        logic blocking;
        logic emit_last;
        logic out_free;
    } t_stat;

endpackage

/* sv/bpsg_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bpsg_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                                        i_clk,
    input  logic                                        i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                            i_wdata,
    input  logic                                        i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                            o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/bpsg_ctrl.sv */
// Sequencer for the squelch gate: sample intake, root iterations, decision, emission.
// Depends on bpsg_pkg (state enum, command and status structs).
module bpsg_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  bpsg_pkg::t_stat i_stat,
    output bpsg_pkg::t_cmd  o_cmd,
    output logic            o_idle
);
    bpsg_pkg::t_state r_state;
    bpsg_pkg::t_state n_state;
    logic             zero_follow;

    // zeros follow the block only when closed and not in blocking mode
    assign zero_follow = !i_stat.decide && !i_stat.blocking;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bpsg_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            bpsg_pkg::S_IDLE:   if (i_in_valid) n_state = bpsg_pkg::S_SQUARE;
            bpsg_pkg::S_SQUARE: n_state = bpsg_pkg::S_ADD;
            bpsg_pkg::S_ADD:    n_state = bpsg_pkg::S_ROOT;
            bpsg_pkg::S_ROOT:   if (i_stat.root_done) n_state = bpsg_pkg::S_ACCUM;
            bpsg_pkg::S_ACCUM: begin
                n_state = i_stat.block_full ? bpsg_pkg::S_THRESH : bpsg_pkg::S_IDLE;
            end
            bpsg_pkg::S_THRESH: n_state = bpsg_pkg::S_DECIDE;
            bpsg_pkg::S_DECIDE: n_state = bpsg_pkg::S_PLAN;
            bpsg_pkg::S_PLAN: begin
                priority if (i_stat.decide || i_stat.was_open) n_state = bpsg_pkg::S_READ;
                else if (zero_follow) n_state = bpsg_pkg::S_ZERO;
                else n_state = bpsg_pkg::S_IDLE;
            end
            bpsg_pkg::S_READ:   n_state = bpsg_pkg::S_LOAD;
            bpsg_pkg::S_LOAD: begin
                if (i_stat.out_free) begin
                    priority if (!i_stat.emit_last) n_state = bpsg_pkg::S_READ;
                    else if (zero_follow) n_state = bpsg_pkg::S_ZERO;
                    else n_state = bpsg_pkg::S_IDLE;
                end
            end
            bpsg_pkg::S_ZERO: begin
                if (i_stat.out_free && i_stat.emit_last) n_state = bpsg_pkg::S_IDLE;
            end
            default: n_state = bpsg_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            bpsg_pkg::S_IDLE:   o_cmd.take   = i_in_valid;
            bpsg_pkg::S_SQUARE: o_cmd.square = 1'b1;
            bpsg_pkg::S_ADD:    o_cmd.add    = 1'b1;
            bpsg_pkg::S_ROOT:   o_cmd.root   = 1'b1;
            bpsg_pkg::S_ACCUM:  o_cmd.accum  = 1'b1;
            bpsg_pkg::S_THRESH: o_cmd.thresh = 1'b1;
            bpsg_pkg::S_DECIDE: begin
                o_cmd.decide   = 1'b1;
                o_cmd.emit_clr = 1'b1;
            end
            bpsg_pkg::S_PLAN: begin
                // nothing to emit: close the block here
                o_cmd.finish = !(i_stat.decide || i_stat.was_open) && !zero_follow;
            end
            bpsg_pkg::S_READ:   o_cmd.rd = 1'b1;
            bpsg_pkg::S_LOAD: begin
                if (i_stat.out_free) begin
                    o_cmd.load_data = 1'b1;
                    o_cmd.burst_end = i_stat.emit_last && !zero_follow;
                    o_cmd.emit_next = !i_stat.emit_last;
                    o_cmd.emit_clr  = i_stat.emit_last && zero_follow;
                    o_cmd.finish    = i_stat.emit_last && !zero_follow;
                end
            end
            bpsg_pkg::S_ZERO: begin
                if (i_stat.out_free) begin
                    o_cmd.load_zero = 1'b1;
                    o_cmd.burst_end = i_stat.emit_last;
                    o_cmd.emit_next = !i_stat.emit_last;
                    o_cmd.finish    = i_stat.emit_last;
                end
            end
            default: o_cmd = '0;
        endcase
    end

    assign o_idle = (r_state == bpsg_pkg::S_IDLE);

endmodule

/* sv/bpsg_dp.sv */
// Datapath of the squelch gate: config registers, magnitude unit, block sum,
// threshold, sample store and output register. Depends on bpsg_pkg and bpsg_ram.
module bpsg_dp #(
    parameter int MAX_BLOCK   = 32,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [bpsg_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [bpsg_pkg::CFG_W-1:0]      i_cfg_data,
    input  logic [SAMPLE_BITS-1:0]          i_in_i,
    input  logic [SAMPLE_BITS-1:0]          i_in_q,
    input  logic                            i_out_stall,
    input  bpsg_pkg::t_cmd                  i_cmd,
    output bpsg_pkg::t_stat                 o_stat,
    output logic                            o_out_valid,
    output logic [SAMPLE_BITS-1:0]          o_out_i,
    output logic [SAMPLE_BITS-1:0]          o_out_q,
    output logic                            o_burst_end,
    output logic                            o_gate_open
);
    localparam int AW       = (MAX_BLOCK > 1) ? $clog2(MAX_BLOCK) : 1;
    localparam int CNT_W    = $clog2(MAX_BLOCK + 1);
    localparam int ROOT_CYC = (SAMPLE_BITS + 1) / 2;
    localparam int RS       = 2 * ROOT_CYC;
    localparam int RAD_W    = 2 * RS;
    localparam int REM_W    = RS + 2;
    localparam int IT_W     = (ROOT_CYC > 1) ? $clog2(ROOT_CYC) : 1;
    localparam int SUM_W    = SAMPLE_BITS + CNT_W;
    localparam int PROD_W   = bpsg_pkg::LEVEL_W + CNT_W;
    localparam int CMP_W    = (SUM_W > PROD_W) ? SUM_W : PROD_W;
    localparam int SQ_W     = 2 * SAMPLE_BITS;

    // configuration
    logic [bpsg_pkg::LEN_W-1:0]   r_len;
    logic [bpsg_pkg::LEVEL_W-1:0] r_level;
    logic                         r_blocking;
    logic [CNT_W-1:0]             len_eff;

    // magnitude unit
    logic [SAMPLE_BITS-1:0] r_ai, r_aq;
    logic [SQ_W-1:0]        r_sqi, r_sqq;
    logic [RAD_W-1:0]       r_rad, n_rad;
    logic [REM_W-1:0]       r_rem, n_rem;
    logic [RS-1:0]          r_root, n_root;
    logic [IT_W-1:0]        r_it;

    // block state
    logic [SUM_W-1:0]  r_sum;
    logic [CNT_W-1:0]  r_fill;
    logic [CNT_W-1:0]  r_k;
    logic [PROD_W-1:0] r_prod;
    logic              r_decide;
    logic              r_open;

    // store and output
    logic [2*SAMPLE_BITS-1:0] ram_rdata;
    logic                     r_out_valid;
    logic [SAMPLE_BITS-1:0]   r_out_i, r_out_q;
    logic                     r_burst_end, r_gate_open;
    logic                     out_free;

    always_comb begin
        priority if (r_len == '0) len_eff = CNT_W'(1);
        else if (r_len > bpsg_pkg::LEN_W'(MAX_BLOCK)) len_eff = CNT_W'(MAX_BLOCK);
        else len_eff = CNT_W'(r_len);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len      <= bpsg_pkg::RST_BLOCK_LEN;
            r_level    <= bpsg_pkg::RST_SQUELCH;
            r_blocking <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                bpsg_pkg::REG_BLOCK_LEN: r_len      <= i_cfg_data[bpsg_pkg::LEN_W-1:0];
                bpsg_pkg::REG_SQUELCH:   r_level    <= i_cfg_data[bpsg_pkg::LEVEL_W-1:0];
                bpsg_pkg::REG_BLOCKING:  r_blocking <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // two root digits per cycle, restoring method
    always_comb begin
        logic [REM_W-1:0] rem;
        logic [RS-1:0]    root;
        logic [RAD_W-1:0] rad;
        logic [REM_W-1:0] shifted;
        logic [REM_W-1:0] trial;
        rem  = r_rem;
        root = r_root;
        rad  = r_rad;
        for (int s = 0; s < 2; s++) begin
            shifted = {rem[REM_W-3:0], rad[RAD_W-1 -: 2]};
            trial   = {root, 2'b01};
            rad     = {rad[RAD_W-3:0], 2'b00};
            if (shifted >= trial) begin
                rem  = shifted - trial;
                root = {root[RS-2:0], 1'b1};
            end else begin
                rem  = shifted;
                root = {root[RS-2:0], 1'b0};
            end
        end
        n_rem  = rem;
        n_root = root;
        n_rad  = rad;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_ai <= i_in_i[SAMPLE_BITS-1] ? (~i_in_i + 1'b1) : i_in_i;
            r_aq <= i_in_q[SAMPLE_BITS-1] ? (~i_in_q + 1'b1) : i_in_q;
        end
        if (i_cmd.square) begin
            r_sqi <= r_ai * r_ai;
            r_sqq <= r_aq * r_aq;
        end
        if (i_cmd.add) begin
            r_rad  <= RAD_W'({1'b0, r_sqi} + {1'b0, r_sqq});
            r_rem  <= '0;
            r_root <= '0;
            r_it   <= '0;
        end else if (i_cmd.root) begin
            r_rad  <= n_rad;
            r_rem  <= n_rem;
            r_root <= n_root;
            r_it   <= r_it + 1'b1;
        end
        if (i_cmd.thresh) begin
            r_prod <= r_level * r_fill;
        end
        if (i_cmd.decide) begin
            r_decide <= CMP_W'(r_sum) > CMP_W'(r_prod);
        end
        if (i_cmd.emit_clr) begin
            r_k <= '0;
        end else if (i_cmd.emit_next) begin
            r_k <= r_k + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum  <= '0;
            r_fill <= '0;
            r_open <= 1'b0;
        end else if (i_cmd.finish) begin
            r_sum  <= '0;
            r_fill <= '0;
            r_open <= r_decide;
        end else if (i_cmd.accum) begin
            r_sum  <= r_sum + SUM_W'(r_root);
            r_fill <= r_fill + 1'b1;
        end
    end

    bpsg_ram #(
        .WIDTH (2 * SAMPLE_BITS),
        .DEPTH (MAX_BLOCK)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (i_cmd.take),
        .i_waddr (r_fill[AW-1:0]),
        .i_wdata ({i_in_i, i_in_q}),
        .i_re    (i_cmd.rd),
        .i_raddr (r_k[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    assign out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_data || i_cmd.load_zero) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_data) begin
            r_out_i     <= ram_rdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
            r_out_q     <= ram_rdata[SAMPLE_BITS-1:0];
            r_burst_end <= i_cmd.burst_end;
            r_gate_open <= r_decide;
        end else if (i_cmd.load_zero) begin
            r_out_i     <= '0;
            r_out_q     <= '0;
            r_burst_end <= i_cmd.burst_end;
            r_gate_open <= 1'b0;
        end
    end

    always_comb begin
        o_stat.root_done  = (r_it == IT_W'(ROOT_CYC - 1));
        o_stat.block_full = ((r_fill + 1'b1) >= len_eff);
        o_stat.decide     = r_decide;
        o_stat.was_open   = r_open;
        o_stat.blocking   = r_blocking;
        o_stat.emit_last  = ((r_k + 1'b1) == r_fill);
        o_stat.out_free   = out_free;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_i     = r_out_i;
    assign o_out_q     = r_out_q;
    assign o_burst_end = r_burst_end;
    assign o_gate_open = r_gate_open;

endmodule

/* sv/block_power_squelch_gate.sv */
// Top level of the block power squelch gate: sequencer plus datapath.
// Depends on bpsg_pkg, bpsg_ctrl, bpsg_dp and bpsg_ram.
//
// Collects blocks of block_len I/Q words, sums the integer magnitude of each word and,
// at block end, opens the gate when the sum exceeds the threshold register times n.
// Each input word passes through the idle cycle that takes it, the square, add and
// accumulate steps, and the shared square-root unit that resolves two result bits a
// cycle; the word that closes a block then passes the threshold, decision and planning
// steps. Each stored word is then read from the store and loaded into the output
// register, and zero words follow at one a cycle while the output is not stalled, up
// to 2n words per block, and no input word is taken until the last of them has been
// loaded into the output register. The user must write configuration registers only
// between blocks' words while idle; the block itself does not enforce this.
module block_power_squelch_gate #(
    parameter int MAX_BLOCK   = 32,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [bpsg_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [bpsg_pkg::CFG_W-1:0]      i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [SAMPLE_BITS-1:0]          i_in_i,
    input  logic [SAMPLE_BITS-1:0]          i_in_q,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [SAMPLE_BITS-1:0]          o_out_i,
    output logic [SAMPLE_BITS-1:0]          o_out_q,
    output logic                            o_burst_end,
    output logic                            o_gate_open
);
    bpsg_pkg::t_cmd  cmd;
    bpsg_pkg::t_stat stat;
    logic            idle;

    bpsg_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (stat),
        .o_cmd      (cmd),
        .o_idle     (idle)
    );

    bpsg_dp #(
        .MAX_BLOCK   (MAX_BLOCK),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_i      (i_in_i),
        .i_in_q      (i_in_q),
        .i_out_stall (i_out_stall),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .o_out_i     (o_out_i),
        .o_out_q     (o_out_q),
        .o_burst_end (o_burst_end),
        .o_gate_open (o_gate_open)
    );

    // hold off words during reset and while a word or block is in hand
    assign o_in_stall = !idle || !i_rst_n;

endmodule

/* sv/bpsg_checker.sv */
// Port-level checks for the squelch gate, bound to the top level.
// Depends on block_power_squelch_gate's port list only.
module bpsg_checker #(
    parameter int SAMPLE_BITS = 16
) (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_in_valid,
    input logic                            o_in_stall,
    input logic                            o_out_valid,
    input logic                            i_out_stall,
    input logic [SAMPLE_BITS-1:0]          o_out_i,
    input logic [SAMPLE_BITS-1:0]          o_out_q,
    input logic                            o_burst_end,
    input logic                            o_gate_open
);
    // a stalled output word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_i)
            && $stable(o_out_q) && $stable(o_burst_end) && $stable(o_gate_open))
        else $error("stalled output word changed");

    // reset empties the output register
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // every accepted word keeps the magnitude unit busy and stalls the input in the next cycle
    a_busy_after_take: assert property (@(posedge i_clk)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input not stalled after an accepted word");

    // a word that is not the end of a burst means the burst is still running
    a_burst_busy: assert property (@(posedge i_clk)
        o_out_valid && !o_burst_end |-> o_in_stall)
        else $error("input taken in the middle of a burst");

endmodule

bind block_power_squelch_gate bpsg_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_bpsg_checker (.*);

/* dv/testbench.sv */
// Self-checking bench for block_power_squelch_gate: directed and random I/Q traffic,
// an in-bench mirror of the gate's block decisions, and random stalls on both channels.
// Depends on bpsg_pkg and the block_power_squelch_gate RTL.
`timescale 1ns / 100ps

module testbench;

    localparam int DEPTH      = 32;
    localparam int SETTLE     = 40;
    localparam int LONG_HOLD  = 300;
    localparam int WORD_GOAL  = 215;
    localparam int MAX_SHOWN  = 40;

    typedef enum int {P_RAW, P_QUIET, P_LOUD, P_BORDER} amp_profile_t;

    typedef struct packed {
        logic [15:0] i;
        logic [15:0] q;
        logic        burst_end;
        logic        gate_open;
    } gate_word_t;

    // Tracks the block fill, magnitude sum and gate flag; queues the words each block releases.
    class squelch_mirror;
        logic [bpsg_pkg::LEN_W-1:0]   len_reg;
        logic [bpsg_pkg::LEVEL_W-1:0] level_reg;
        logic                         blocking_reg;
        logic [15:0]                  buf_i [DEPTH];
        logic [15:0]                  buf_q [DEPTH];
        int unsigned                  mag_sum;
        int unsigned                  fill;
        bit                           was_open;
        gate_word_t                   due_words [$];
        int                           errors;
        int                           checked;
        int                           opened;
        int                           shut;

        function new();
            len_reg      = bpsg_pkg::RST_BLOCK_LEN;
            level_reg    = bpsg_pkg::RST_SQUELCH;
            blocking_reg = 1'b0;
            mag_sum      = 0;
            fill         = 0;
            was_open     = 1'b0;
            errors       = 0;
            checked      = 0;
            opened       = 0;
            shut         = 0;
        endfunction

        function void set_reg(logic [bpsg_pkg::CFG_IDX_W-1:0] idx,
                              logic [bpsg_pkg::CFG_W-1:0] data);
            case (idx)
                bpsg_pkg::REG_BLOCK_LEN: len_reg      = data[bpsg_pkg::LEN_W-1:0];
                bpsg_pkg::REG_SQUELCH:   level_reg    = data[bpsg_pkg::LEVEL_W-1:0];
                bpsg_pkg::REG_BLOCKING:  blocking_reg = data[0];
                default: ;
            endcase
        endfunction

        function int unsigned magnitude16(logic [15:0] raw);
            int v;
            v = $signed(raw);
            return (v < 0) ? -v : v;
        endfunction

        function int unsigned root_floor(longint unsigned v);
            longint unsigned r;
            longint unsigned t;
            r = 0;
            for (int b = 16; b >= 0; b--) begin
                t = r | (64'd1 << b);
                if (t * t <= v)
                    r = t;
            end
            return 32'(r);
        endfunction

        function int pending();
            return due_words.size();
        endfunction

        function void take_word(logic [15:0] wi, logic [15:0] wq);
            int unsigned lim;
            int unsigned n;
            int unsigned total;
            int unsigned c;
            longint unsigned ai;
            longint unsigned aq;
            bit open_now;
            bit emit;
            bit zero_fill;
            gate_word_t w;
            lim = (len_reg == 0) ? 1 : (len_reg > DEPTH) ? DEPTH : len_reg;
            ai = magnitude16(wi);
            aq = magnitude16(wq);
            buf_i[fill] = wi;
            buf_q[fill] = wq;
            mag_sum += root_floor(ai * ai + aq * aq);
            fill++;
            if (fill < lim)
                return;
            n = fill;
            open_now  = mag_sum > int'(level_reg) * n;
            emit      = open_now || was_open;
            zero_fill = !open_now && !blocking_reg;
            total     = (emit ? n : 0) + (zero_fill ? n : 0);
            c = 0;
            if (emit) begin
                for (int k = 0; k < n; k++) begin
                    w = '{buf_i[k], buf_q[k], (c == total - 1), open_now};
                    due_words.push_back(w);
                    c++;
                end
            end
            if (zero_fill) begin
                for (int k = 0; k < n; k++) begin
                    w = '{16'd0, 16'd0, (c == total - 1), 1'b0};
                    due_words.push_back(w);
                    c++;
                end
            end
            if (open_now)
                opened++;
            else
                shut++;
            was_open = open_now;
            mag_sum  = 0;
            fill     = 0;
        endfunction

        function void check_field(string what, logic [15:0] exp_v, logic [15:0] got_v);
            if (got_v !== exp_v) begin
                errors++;
                if (errors <= MAX_SHOWN)
                    $display("%0t: %s mismatch, expected %h, got %h", $time, what, exp_v, got_v);
            end
        endfunction

        function void match_word(logic [15:0] oi, logic [15:0] oq, logic be, logic go);
            gate_word_t w;
            if (due_words.size() == 0) begin
                errors++;
                if (errors <= MAX_SHOWN)
                    $display("%0t: unexpected word, expected none, got i=%h q=%h end=%b open=%b",
                             $time, oi, oq, be, go);
                return;
            end
            w = due_words.pop_front();
            checked++;
            check_field("out_i", w.i, oi);
            check_field("out_q", w.q, oq);
            check_field("burst_end", {15'd0, w.burst_end}, {15'd0, be});
            check_field("gate_open", {15'd0, w.gate_open}, {15'd0, go});
        endfunction
    endclass

    logic                             i_clk      = 1'b0;
    logic                             i_rst_n    = 1'b0;
    logic                             i_cfg_we   = 1'b0;
    logic [bpsg_pkg::CFG_IDX_W-1:0]   i_cfg_idx  = bpsg_pkg::REG_BLOCK_LEN;
    logic [bpsg_pkg::CFG_W-1:0]       i_cfg_data = '0;
    logic                             i_in_valid = 1'b0;
    logic                             o_in_stall;
    logic [15:0]                      i_in_i     = '0;
    logic [15:0]                      i_in_q     = '0;
    logic                             o_out_valid;
    logic                             i_out_stall = 1'b0;
    logic [15:0]                      o_out_i;
    logic [15:0]                      o_out_q;
    logic                             o_burst_end;
    logic                             o_gate_open;

    squelch_mirror mirror = new();
    bit            calm     = 1'b0;
    bit            hold_req = 1'b0;
    int            words_sent = 0;
    int            phases     = 0;

    block_power_squelch_gate dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_i      (i_in_i),
        .i_in_q      (i_in_q),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_i     (o_out_i),
        .o_out_q     (o_out_q),
        .o_burst_end (o_burst_end),
        .o_gate_open (o_gate_open)
    );

    always #4 i_clk = ~i_clk;

    initial begin
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // Output side: check each accepted word, then draw the next stall.
    initial begin : sink
        int unsigned hold_left;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (o_out_valid === 1'b1 && !i_out_stall) begin
                mirror.match_word(o_out_i, o_out_q, o_burst_end, o_gate_open);
                hold_left = calm ? 0 : $urandom_range(0, 4);
            end else if (hold_left == 0 && !calm && $urandom_range(0, 7) == 0) begin
                hold_left = $urandom_range(1, 4);
            end
            if (hold_req) begin
                hold_left = LONG_HOLD;
                hold_req  = 1'b0;
            end
            i_out_stall <= (hold_left != 0);
            if (hold_left != 0)
                hold_left--;
        end
    end

    task automatic send_word(logic [15:0] wi, logic [15:0] wq);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_i     <= wi;
        i_in_q     <= wq;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        mirror.take_word(wi, wq);
        words_sent++;
    endtask

    // Drop valid and hold until every due word is back, then let the block settle.
    task automatic drain(int settle);
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (mirror.pending() != 0);
        repeat (settle) @(posedge i_clk);
    endtask

    task automatic configure(int unsigned len, int unsigned level, bit blocking);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= bpsg_pkg::REG_BLOCK_LEN;
        i_cfg_data <= bpsg_pkg::CFG_W'(len);
        @(posedge i_clk);
        mirror.set_reg(bpsg_pkg::REG_BLOCK_LEN, bpsg_pkg::CFG_W'(len));
        i_cfg_idx  <= bpsg_pkg::REG_SQUELCH;
        i_cfg_data <= bpsg_pkg::CFG_W'(level);
        @(posedge i_clk);
        mirror.set_reg(bpsg_pkg::REG_SQUELCH, bpsg_pkg::CFG_W'(level));
        i_cfg_idx  <= bpsg_pkg::REG_BLOCKING;
        i_cfg_data <= bpsg_pkg::CFG_W'(blocking);
        @(posedge i_clk);
        mirror.set_reg(bpsg_pkg::REG_BLOCKING, bpsg_pkg::CFG_W'(blocking));
        i_cfg_we   <= 1'b0;
    endtask

    function automatic logic [15:0] pick_component(int unsigned cap);
        int mag;
        mag = $urandom_range(0, (cap > 32767) ? 32767 : cap);
        return $urandom_range(0, 1) ? 16'(-mag) : 16'(mag);
    endfunction

    task automatic send_block(int unsigned n, amp_profile_t prof, int unsigned level);
        logic [15:0] wi;
        logic [15:0] wq;
        for (int k = 0; k < n; k++) begin
            case (prof)
                P_RAW: begin
                    wi = 16'($urandom);
                    wq = 16'($urandom);
                end
                P_QUIET: begin
                    wi = pick_component(level / 2);
                    wq = pick_component(level / 2);
                end
                P_LOUD: begin
                    wi = pick_component(level * 2 + 1);
                    wq = pick_component(level * 2 + 1);
                end
                default: begin
                    // magnitude lands exactly on the level: gate must stay shut
                    wi = (level > 32767) ? 16'd32767 : 16'(level);
                    wq = 16'd0;
                end
            endcase
            send_word(wi, wq);
        end
    endtask

    task automatic run_phase();
        int unsigned r;
        int unsigned len;
        int unsigned eff;
        int unsigned level;
        int unsigned blocks;
        bit          blocking;
        drain(SETTLE);
        calm = ($urandom_range(0, 3) == 0);
        r = $urandom_range(0, 11);
        len = (r < 7) ? $urandom_range(1, 6) : (r == 7) ? 0 : (r == 8) ? 63 :
              (r == 9) ? 32 : $urandom_range(1, 32);
        r = $urandom_range(0, 9);
        level = (r == 0) ? 0 : (r == 1) ? 65535 : (r < 7) ? $urandom_range(0, 2000) :
                $urandom_range(0, 40000);
        blocking = $urandom_range(0, 2) == 0;
        configure(len, level, blocking);
        eff = (len == 0) ? 1 : (len > DEPTH) ? DEPTH : len;
        blocks = (eff > 8) ? 1 : $urandom_range(2, 5);
        for (int b = 0; b < blocks; b++) begin
            send_block(eff, amp_profile_t'($urandom_range(0, 3)), level);
            if ($urandom_range(0, 5) == 0)
                drain(0);
        end
        // leave a part-filled block behind now and then; the next setting may cut it short
        if (eff > 1 && $urandom_range(0, 3) == 0)
            send_block($urandom_range(1, eff - 1), amp_profile_t'($urandom_range(0, 3)), level);
        phases++;
    endtask

    initial begin : stimulus
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // single-word blocks: silent block at level zero, then full-scale corners
        configure(1, 0, 0);
        send_word(16'h0000, 16'h0000);
        send_word(16'h8000, 16'h8000);
        send_word(16'h7fff, 16'h7fff);
        // magnitude equal to the level stays shut and flushes the open block
        drain(SETTLE);
        configure(1, 100, 0);
        send_word(16'd100, 16'd0);
        send_word(16'd0, -16'sd101);
        send_word(-16'sd100, 16'd0);
        // blocking mode: shut blocks stay silent unless the previous one was open
        drain(SETTLE);
        configure(1, 100, 1);
        send_word(16'h0000, 16'h0000);
        send_word(16'h0000, 16'h0000);
        send_word(16'h7fff, 16'h8000);
        send_word(16'd1, 16'd1);
        // zero length behaves as one; top level never reachable
        drain(SETTLE);
        configure(0, 65535, 0);
        send_word(16'h8000, 16'h8000);
        // shorten the block under a part-filled store
        drain(SETTLE);
        configure(4, 0, 0);
        send_word(16'd1, 16'd0);
        send_word(16'd0, 16'hffff);
        send_word(16'h8000, 16'd0);
        drain(SETTLE);
        configure(2, 0, 0);
        send_word(16'd5, 16'd5);

        // long output hold while input keeps coming, so the block backs up
        drain(SETTLE);
        configure(3, 0, 0);
        hold_req = 1'b1;
        repeat (4) send_block(3, P_RAW, 0);

        while (words_sent < WORD_GOAL)
            run_phase();
        drain(SETTLE);

        $display("Sent %0d words over %0d random settings; %0d result words checked.",
                 words_sent, phases, mirror.checked);
        $display("Blocks decided: %0d open, %0d shut.", mirror.opened, mirror.shut);
        if (mirror.errors == 0 && mirror.pending() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
